>>> rtl/aesp_pkg.sv
// ---------------------------------------------------------------------------
// aesp_pkg
// Shared types and constants for the escape sequence parser.
// ---------------------------------------------------------------------------
package aesp_pkg;

    localparam int MAX_ARGS      = 10;
    localparam int ARG_MAX_VALUE = 999;
    localparam int ARG_W         = 10;
    localparam int CNT_W         = $clog2(MAX_ARGS + 1);
    localparam int IDX_W         = $clog2(MAX_ARGS);

    localparam logic [3:0] CMD_PRINT  = 4'd0;
    localparam logic [3:0] CMD_UP     = 4'd1;
    localparam logic [3:0] CMD_DOWN   = 4'd2;
    localparam logic [3:0] CMD_RIGHT  = 4'd3;
    localparam logic [3:0] CMD_LEFT   = 4'd4;
    localparam logic [3:0] CMD_AT     = 4'd5;
    localparam logic [3:0] CMD_CLEAR  = 4'd6;
    localparam logic [3:0] CMD_EOL    = 4'd7;
    localparam logic [3:0] CMD_ATTR   = 4'd8;
    localparam logic [3:0] CMD_REPORT = 4'd9;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_ESCAPE = 2'd1;
    localparam logic [1:0] MODE_CSI    = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic       load;     // capture input, decode byte
        logic       sgr_step; // apply one stored argument
        logic       emit;     // load output register
    } aesp_ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic       sgr_start; // decoded byte is SGR final
        logic       sgr_done;  // last stored argument reached
        logic       has_res;   // decoded byte gives a result
    } aesp_stat_t;

    typedef struct packed {
        logic [7:0] attribute;
        logic [9:0] target_row;
        logic [9:0] target_col;
        logic [9:0] repeat_res;
        logic [7:0] glyph;
        logic [3:0] cmd;
    } aesp_res_t;

    function automatic logic [2:0] colour_map(input logic [2:0] c);
        case (c)
            3'd0: colour_map = 3'd0;
            3'd1: colour_map = 3'd4;
            3'd2: colour_map = 3'd2;
            3'd3: colour_map = 3'd6;
            3'd4: colour_map = 3'd1;
            3'd5: colour_map = 3'd5;
            3'd6: colour_map = 3'd3;
            default: colour_map = 3'd7;
        endcase
    endfunction

endpackage

>>> rtl/aesp_ctrl.sv
// ---------------------------------------------------------------------------
// aesp_ctrl
// Sequencer: accept byte, walk SGR arguments, present result.
// ---------------------------------------------------------------------------
module aesp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output aesp_pkg::aesp_ctrl_t ctrl,
    input  aesp_pkg::aesp_stat_t stat
);
    import aesp_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DEC  = 2'd1;
    localparam logic [1:0] ST_SGR  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       ovalid_reg, ovalid_next;

    // output register frees the input side once the result is held
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = ovalid_reg;

    always_comb begin
        state_next    = state_reg;
        ovalid_next   = ovalid_reg;
        ctrl          = '0;
        if (out_valid && out_ready) begin
            ovalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    ctrl.load  = 1'b1;
                    state_next = ST_DEC;
                end
            end
            ST_DEC: begin
                if (stat.sgr_start) begin
                    state_next = stat.sgr_done ? ST_FIN : ST_SGR;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_SGR: begin
                ctrl.sgr_step = 1'b1;
                if (stat.sgr_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!stat.has_res) begin
                    state_next = ST_IDLE;
                end else if (!ovalid_reg || out_ready) begin
                    ctrl.emit   = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

`ifndef SYNTHESIS
    a_emit_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.emit |-> state_reg == ST_FIN) else $error("emit outside finish");
    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.emit |=> out_valid) else $error("emitted result not valid");
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load |=> !in_ready) else $error("busy after load not shown");
`endif

endmodule

>>> rtl/aesp_dp.sv
// ---------------------------------------------------------------------------
// aesp_dp
// Parser state, argument store, attributes and result register.
// ---------------------------------------------------------------------------
module aesp_dp (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [7:0]        in_byte,
    input  logic [7:0]        cursor_col,
    input  logic [7:0]        cursor_row,
    input  aesp_pkg::aesp_ctrl_t ctrl,
    output aesp_pkg::aesp_stat_t stat,
    output aesp_pkg::aesp_res_t  res
);
    import aesp_pkg::*;

    logic [7:0]       ch_reg, col_reg, row_reg;
    logic [1:0]       mode_reg, mode_next;
    logic [ARG_W-1:0] args_reg [MAX_ARGS];
    logic [ARG_W-1:0] args_next [MAX_ARGS];
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [ARG_W-1:0] acc_reg, acc_next;
    logic [2:0]       fg_reg, fg_next, bg_reg, bg_next;
    logic             blink_reg, blink_next, bright_reg, bright_next;
    logic             hib_reg, hib_next;
    logic [7:0]       scol_reg, scol_next, srow_reg, srow_next;
    logic [CNT_W-1:0] sgr_i_reg, sgr_i_next;
    logic             has_reg, has_next;
    aesp_res_t        pend_reg, pend_next, res_reg;
    logic             dec_reg;

    logic [ARG_W+3:0] acc_mul;
    logic [ARG_W-1:0] a0, a1, sv;
    logic [CNT_W-1:0] cnt_p;
    logic             is_digit;

    assign res = res_reg;
    assign is_digit = (ch_reg >= 8'h30) && (ch_reg <= 8'h39);
    assign acc_mul = {4'd0, acc_reg} * (ARG_W+4)'(10)
                   + {{(ARG_W){1'b0}}, 4'(ch_reg - 8'h30)};
    assign sv = args_reg[sgr_i_reg[IDX_W-1:0]];
    // count including the argument pushed by this final byte
    assign cnt_p = (cnt_reg < CNT_W'(MAX_ARGS)) ? cnt_reg + 1'b1 : cnt_reg;

    assign stat.sgr_start = dec_reg && mode_reg == MODE_CSI && !is_digit
                            && ch_reg == 8'h6d;
    assign stat.sgr_done  = (sgr_i_next >= (dec_reg ? cnt_p : cnt_reg));
    assign stat.has_res   = has_reg;

    always_comb begin
        mode_next   = mode_reg;
        args_next   = args_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        fg_next     = fg_reg;
        bg_next     = bg_reg;
        blink_next  = blink_reg;
        bright_next = bright_reg;
        hib_next    = hib_reg;
        scol_next   = scol_reg;
        srow_next   = srow_reg;
        sgr_i_next  = sgr_i_reg;
        has_next    = has_reg;
        pend_next   = pend_reg;
        a0          = args_reg[0];
        a1          = args_reg[1];
        if (cnt_reg == '0) a0 = acc_reg;
        if (cnt_reg == CNT_W'(1)) a1 = acc_reg;

        if (dec_reg) begin
            has_next  = 1'b0;
            pend_next = '0;
            sgr_i_next = '0;
            case (mode_reg)
                MODE_ESCAPE: begin
                    mode_next = MODE_NORMAL;
                    if (ch_reg == 8'h5b) begin
                        mode_next = MODE_CSI;
                        for (int i = 0; i < MAX_ARGS; i++) args_next[i] = '0;
                        cnt_next = '0;
                        acc_next = '0;
                    end else if (ch_reg == 8'h4b) begin
                        has_next      = 1'b1;
                        pend_next.cmd = CMD_CLEAR;
                    end
                end
                MODE_CSI: begin
                    if (is_digit) begin
                        acc_next = (acc_mul > (ARG_W+4)'(ARG_MAX_VALUE))
                                 ? ARG_W'(ARG_MAX_VALUE) : acc_mul[ARG_W-1:0];
                    end else begin
                        acc_next = '0;
                        if (cnt_reg < CNT_W'(MAX_ARGS)) begin
                            args_next[cnt_reg[IDX_W-1:0]] = acc_reg;
                        end
                        cnt_next = cnt_p;
                        if (ch_reg != 8'h3b) begin
                            mode_next = MODE_NORMAL;
                            case (ch_reg)
                                8'h41, 8'h42, 8'h43, 8'h44: begin
                                    has_next = 1'b1;
                                    pend_next.cmd = CMD_UP + 4'(ch_reg - 8'h41);
                                    pend_next.repeat_res = (a0 == '0) ? ARG_W'(1) : a0;
                                end
                                8'h48, 8'h66: begin
                                    has_next = 1'b1;
                                    pend_next.cmd = CMD_AT;
                                    pend_next.target_row = (a0 != '0) ? a0 - 1'b1 : a0;
                                    pend_next.target_col = (a1 != '0) ? a1 - 1'b1 : a1;
                                end
                                8'h4a: begin
                                    has_next = (a0 == ARG_W'(1)) || (a0 == ARG_W'(2));
                                    pend_next.cmd = CMD_CLEAR;
                                end
                                8'h4b: begin
                                    has_next = 1'b1;
                                    pend_next.cmd = CMD_EOL;
                                end
                                8'h6d: begin
                                    has_next = 1'b1;
                                    pend_next.cmd = CMD_ATTR;
                                end
                                8'h73: begin
                                    scol_next = col_reg;
                                    srow_next = row_reg;
                                end
                                8'h75: begin
                                    has_next = 1'b1;
                                    pend_next.cmd = CMD_AT;
                                    pend_next.target_col = {2'b0, scol_reg};
                                    pend_next.target_row = {2'b0, srow_reg};
                                end
                                8'h6e: begin
                                    has_next = (a0 == ARG_W'(6));
                                    pend_next.cmd = CMD_REPORT;
                                    pend_next.target_col = {2'b0, col_reg} + 1'b1;
                                    pend_next.target_row = {2'b0, row_reg} + 1'b1;
                                end
                                default: has_next = 1'b0;
                            endcase
                        end
                    end
                end
                default: begin
                    mode_next = MODE_NORMAL;
                    if (ch_reg == 8'h1b) begin
                        mode_next = MODE_ESCAPE;
                    end else if (ch_reg == 8'h0c) begin
                        has_next      = 1'b1;
                        pend_next.cmd = CMD_CLEAR;
                    end else begin
                        has_next        = 1'b1;
                        pend_next.cmd   = CMD_PRINT;
                        pend_next.glyph = ch_reg;
                        if (ch_reg >= 8'h20 && hib_reg) pend_next.glyph[7] = 1'b1;
                    end
                end
            endcase
        end

        if (ctrl.sgr_step) begin
            sgr_i_next = sgr_i_reg + 1'b1;
            case (sv)
                ARG_W'(0): begin
                    fg_next = 3'd7; bg_next = 3'd0; blink_next = 1'b0;
                    hib_next = 1'b0; bright_next = 1'b0;
                end
                ARG_W'(1):  bright_next = 1'b1;
                ARG_W'(5):  blink_next  = 1'b1;
                ARG_W'(7): begin
                    fg_next = 3'd0; bg_next = 3'd7; bright_next = 1'b0;
                end
                ARG_W'(8):  fg_next  = bg_reg;
                ARG_W'(10): hib_next = 1'b0;
                ARG_W'(12): hib_next = 1'b1;
                default: begin
                    if (sv >= ARG_W'(30) && sv <= ARG_W'(37))
                        fg_next = colour_map(3'(sv - ARG_W'(30)));
                    else if (sv >= ARG_W'(40) && sv <= ARG_W'(47))
                        bg_next = colour_map(3'(sv - ARG_W'(40)));
                end
            endcase
        end

        // arguments cleared after every final byte, once SGR has used them
        if (ctrl.emit || (!ctrl.sgr_step && !dec_reg)) begin
            if (mode_reg == MODE_NORMAL && cnt_reg != '0) begin
                for (int i = 0; i < MAX_ARGS; i++) args_next[i] = '0;
                cnt_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_NORMAL;
            for (int i = 0; i < MAX_ARGS; i++) args_reg[i] <= '0;
            cnt_reg    <= '0;
            acc_reg    <= '0;
            fg_reg     <= 3'd7;
            bg_reg     <= 3'd0;
            blink_reg  <= 1'b0;
            bright_reg <= 1'b0;
            hib_reg    <= 1'b0;
            scol_reg   <= '0;
            srow_reg   <= '0;
            sgr_i_reg  <= '0;
            has_reg    <= 1'b0;
            dec_reg    <= 1'b0;
        end else begin
            mode_reg   <= mode_next;
            args_reg   <= args_next;
            cnt_reg    <= cnt_next;
            acc_reg    <= acc_next;
            fg_reg     <= fg_next;
            bg_reg     <= bg_next;
            blink_reg  <= blink_next;
            bright_reg <= bright_next;
            hib_reg    <= hib_next;
            scol_reg   <= scol_next;
            srow_reg   <= srow_next;
            sgr_i_reg  <= sgr_i_next;
            has_reg    <= has_next;
            dec_reg    <= ctrl.load;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
        if (ctrl.load) begin
            ch_reg  <= in_byte;
            col_reg <= cursor_col;
            row_reg <= cursor_row;
        end
        if (ctrl.emit) begin
            res_reg <= pend_reg;
            if (pend_reg.cmd == CMD_ATTR) begin
                res_reg.attribute <= {blink_reg, bg_reg, bright_reg, fg_reg};
            end
        end
    end

`ifndef SYNTHESIS
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_ARGS)) else $error("argument count overflow");
    a_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_reg <= ARG_W'(ARG_MAX_VALUE)) else $error("argument not saturated");
    a_sgr: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.sgr_step |-> sgr_i_reg < cnt_reg) else $error("SGR past stored args");
`endif

endmodule

>>> rtl/ansi_escape_sequence_parser_top.sv
// A byte passes through the accept, decode and finish steps, and its result
// is loaded into the output register at the finish step; an SGR sequence
// also walks each stored argument (up to 10) through the attribute update step.
// A result waits in an output register while the next byte is accepted; the
// finish step of a byte with a result stalls while an earlier one still waits.
// ---------------------------------------------------------------------------
// ansi_escape_sequence_parser_top
// Byte stream escape sequence parser producing display commands.
// ---------------------------------------------------------------------------
module ansi_escape_sequence_parser_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // in_byte, cursor_col, cursor_row
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata   // cmd, glyph, repeat_res, target_col, target_row, attribute, pad
);
    import aesp_pkg::*;

    aesp_ctrl_t ctrl;
    aesp_stat_t stat;
    aesp_res_t  res;

    aesp_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .ctrl(ctrl), .stat(stat)
    );

    aesp_dp u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .in_byte(s_tdata[7:0]), .cursor_col(s_tdata[15:8]),
        .cursor_row(s_tdata[23:16]),
        .ctrl(ctrl), .stat(stat), .res(res)
    );

    assign m_tdata = {6'd0, res.attribute, res.target_row, res.target_col,
                      res.repeat_res, res.glyph, res.cmd};

endmodule
